// ----- rtl/core/ctl_pkg.sv -----
// Shared types and constants for the circular trace log with snapshot.
`default_nettype none
package ctl_pkg;

	localparam int unsigned RING_BYTES = 8192;
	localparam int POS_W = $clog2(RING_BYTES);
	localparam int STORE_DEPTH = 2 * RING_BYTES;
	localparam int STORE_AW = $clog2(STORE_DEPTH);
	localparam int IDX_W = 13;
	localparam int ROOM_W = 14;
	localparam int LEN_W = 14;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_READ    = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [7:0]        data_byte;
		logic [IDX_W-1:0]  read_index;
		logic [ROOM_W-1:0] read_room;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             in_range;
		logic [LEN_W-1:0] readable_length;
		logic             snapshot_present;
	} out_item_t;

	// One store access handed from the front to the back.
	typedef struct packed {
		logic                is_write;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          wdata;
		logic                hit;
		logic [LEN_W-1:0]    len;
		logic                present;
	} op_t;

endpackage
`default_nettype wire

// ----- rtl/core/ctl_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module ctl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/ctl_front.sv -----
// Front end: accepts commands, keeps ring and snapshot state, issues store ops.
`default_nettype none
module ctl_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire ctl_pkg::in_item_t   in_data,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output ctl_pkg::op_t             push_op
);

	localparam int SUM_W = ctl_pkg::POS_W + 1;

	logic                        active_bank_q;
	logic [ctl_pkg::POS_W-1:0]   write_pos_q;
	logic                        ring_wrapped_q;
	logic                        log_started_q;
	logic [ctl_pkg::POS_W-1:0]   snap_pos_q;
	logic                        snap_wrapped_q;
	logic                        snap_valid_q;

	logic                        take;
	logic [ctl_pkg::LEN_W-1:0]   total;
	logic [ctl_pkg::ROOM_W-1:0]  room_m1;
	logic [ctl_pkg::LEN_W-1:0]   len;
	logic                        hit;
	logic [SUM_W-1:0]            sum;
	logic [SUM_W-1:0]            src_full;
	logic [ctl_pkg::POS_W-1:0]   src;
	logic [SUM_W-1:0]            pos_inc;
	logic                        new_bank;
	logic                        nxt_active_bank;
	logic [ctl_pkg::POS_W-1:0]   nxt_write_pos;
	logic                        nxt_ring_wrapped;
	logic                        nxt_log_started;
	logic [ctl_pkg::POS_W-1:0]   nxt_snap_pos;
	logic                        nxt_snap_wrapped;
	logic                        nxt_snap_valid;

	function automatic logic [ctl_pkg::STORE_AW-1:0] bank_addr(
		input logic bank,
		input logic [ctl_pkg::POS_W-1:0] pos
	);
		logic [ctl_pkg::STORE_AW-1:0] base;
		base = bank ? ctl_pkg::STORE_AW'(ctl_pkg::RING_BYTES) : '0;
		return base + ctl_pkg::STORE_AW'(pos);
	endfunction

	assign in_ready = push_ready;
	assign take = in_valid && push_ready;

	always_comb begin
		total = snap_wrapped_q ? ctl_pkg::LEN_W'(ctl_pkg::RING_BYTES)
			: ctl_pkg::LEN_W'(snap_pos_q);
		room_m1 = in_data.read_room - ctl_pkg::ROOM_W'(1);
		len = '0;
		if (snap_valid_q && in_data.read_room != '0) begin
			len = (ctl_pkg::LEN_W'(room_m1) < total) ? ctl_pkg::LEN_W'(room_m1) : total;
		end
		hit = ctl_pkg::LEN_W'(in_data.read_index) < len;
		sum = (snap_wrapped_q ? SUM_W'(snap_pos_q) : '0) + SUM_W'(in_data.read_index);
		src_full = (sum >= SUM_W'(ctl_pkg::RING_BYTES)) ?
			sum - SUM_W'(ctl_pkg::RING_BYTES) : sum;
		src = src_full[ctl_pkg::POS_W-1:0];
		pos_inc = SUM_W'(write_pos_q) + SUM_W'(1);
		new_bank = log_started_q ? ~active_bank_q : active_bank_q;

		nxt_active_bank = active_bank_q;
		nxt_write_pos = write_pos_q;
		nxt_ring_wrapped = ring_wrapped_q;
		nxt_log_started = log_started_q;
		nxt_snap_pos = snap_pos_q;
		nxt_snap_wrapped = snap_wrapped_q;
		nxt_snap_valid = snap_valid_q;

		push_valid = 1'b0;
		push_op = '0;
		push_op.hit = hit;
		push_op.len = len;
		push_op.present = snap_valid_q;

		unique case (in_data.cmd)
			ctl_pkg::CMD_APPEND: begin
				push_valid = in_valid;
				push_op.is_write = 1'b1;
				push_op.addr = bank_addr(active_bank_q, write_pos_q);
				push_op.wdata = in_data.data_byte;
				if (pos_inc >= SUM_W'(ctl_pkg::RING_BYTES)) begin
					nxt_write_pos = '0;
					nxt_ring_wrapped = 1'b1;
				end else begin
					nxt_write_pos = pos_inc[ctl_pkg::POS_W-1:0];
				end
			end
			ctl_pkg::CMD_RESTART: begin
				push_valid = in_valid;
				push_op.is_write = 1'b1;
				push_op.addr = bank_addr(new_bank, '0);
				push_op.wdata = 8'h00;
				if (log_started_q) begin
					nxt_snap_pos = write_pos_q;
					nxt_snap_wrapped = ring_wrapped_q;
					nxt_snap_valid = 1'b1;
				end
				nxt_active_bank = new_bank;
				nxt_log_started = 1'b1;
				nxt_write_pos = '0;
				nxt_ring_wrapped = 1'b0;
			end
			ctl_pkg::CMD_READ: begin
				push_valid = in_valid;
				push_op.is_write = 1'b0;
				push_op.addr = bank_addr(~active_bank_q, src);
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bank_q <= 1'b0;
			write_pos_q <= '0;
			ring_wrapped_q <= 1'b0;
			log_started_q <= 1'b0;
			snap_pos_q <= '0;
			snap_wrapped_q <= 1'b0;
			snap_valid_q <= 1'b0;
		end else if (take) begin
			active_bank_q <= nxt_active_bank;
			write_pos_q <= nxt_write_pos;
			ring_wrapped_q <= nxt_ring_wrapped;
			log_started_q <= nxt_log_started;
			snap_pos_q <= nxt_snap_pos;
			snap_wrapped_q <= nxt_snap_wrapped;
			snap_valid_q <= nxt_snap_valid;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ctl_queue.sv -----
// Short FIFO of store ops between the front and the back.
`default_nettype none
module ctl_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire ctl_pkg::op_t push_op,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output ctl_pkg::op_t      pop_op
);

	ctl_pkg::op_t                entry_q [ctl_pkg::QUEUE_DEPTH];
	logic [ctl_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [ctl_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [ctl_pkg::QUEUE_CW-1:0] count_q;
	logic                         push;
	logic                         pop;

	assign push_ready = count_q != ctl_pkg::QUEUE_CW'(ctl_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ctl_pkg::QUEUE_AW'(ctl_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + ctl_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ctl_pkg::QUEUE_AW'(ctl_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + ctl_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ctl_pkg::QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ctl_pkg::QUEUE_CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ctl_back.sv -----
// Back end: performs store ops and returns read results through an output register.
`default_nettype none
module ctl_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire ctl_pkg::op_t      pop_op,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ctl_pkg::out_item_t     out_data
);

	logic                       s1_valid_q;
	logic                       hit_s1;
	logic [ctl_pkg::LEN_W-1:0]  len_s1;
	logic                       present_s1;
	logic                       out_valid_q;
	ctl_pkg::out_item_t         out_data_q;
	logic                       s1_move;
	logic                       pop;
	logic                       ram_en;
	logic [7:0]                 rdata;

	assign s1_move = s1_valid_q && (!out_valid_q || out_ready);
	assign pop_ready = !s1_valid_q || s1_move;
	assign pop = pop_valid && pop_ready;
	assign ram_en = pop && (pop_op.is_write || pop_op.hit);

	ctl_ram #(
		.WIDTH(8),
		.DEPTH(ctl_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (pop_op.is_write),
		.addr  (pop_op.addr),
		.wdata (pop_op.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (pop && !pop_op.is_write) begin
			hit_s1 <= pop_op.hit;
			len_s1 <= pop_op.len;
			present_s1 <= pop_op.present;
		end
		if (s1_move) begin
			out_data_q.out_byte <= hit_s1 ? rdata : 8'h00;
			out_data_q.in_range <= hit_s1;
			out_data_q.readable_length <= len_s1;
			out_data_q.snapshot_present <= present_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && !pop_op.is_write) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
`default_nettype wire

// ----- rtl/core/circular_trace_log_with_snapshot_top.sv -----
// Top level of the circular trace log with snapshot.
// The block takes one command per cycle while in_ready is high: append writes a
// byte into the active ring, restart swaps the two 8192-byte banks once the log
// has started so the old ring becomes the snapshot, and read returns one
// snapshot byte oldest-first with the readable length. Every command is
// classified and resolved at the input, then passed through a two-entry queue to
// the single-port 16384-byte store, which performs one access per cycle unless
// stalled; that port sets the sustained rate of one command per cycle. A read
// result goes through the queue, the store and the output register. The store
// is not cleared after reset; the log never reads an entry it has not written.
`default_nettype none
module circular_trace_log_with_snapshot_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ctl_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ctl_pkg::out_item_t      out_data
);

	logic         push_valid;
	logic         push_ready;
	ctl_pkg::op_t push_op;
	logic         pop_valid;
	logic         pop_ready;
	ctl_pkg::op_t pop_op;

	ctl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	ctl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	ctl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_range |-> out_data.out_byte == 8'h00)
		else $error("out-of-range read returned nonzero byte");

	a_hit_needs_snap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_range |->
			out_data.snapshot_present && out_data.readable_length != '0)
		else $error("in-range read without snapshot or length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.readable_length <=
			ctl_pkg::LEN_W'(ctl_pkg::RING_BYTES)
			&& (out_data.snapshot_present || out_data.readable_length == '0))
		else $error("readable length out of bounds");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_circular_trace_log_with_snapshot_top.sv -----
// Testbench for the circular trace log: directed table, then random episodes vs a predictor.
`default_nettype none
module tb_circular_trace_log_with_snapshot_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		ctl_pkg::in_item_t  stim;
		logic               fixed;
		ctl_pkg::out_item_t want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	ctl_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ctl_pkg::out_item_t out_data;

	// typed expectation travelling with the current transfer
	logic               row_fixed = 1'b0;
	ctl_pkg::out_item_t row_expect = '0;

	// predictor state
	logic [7:0] mirror_store [0:ctl_pkg::STORE_DEPTH-1];
	logic       log_bank = 1'b0;
	int         wr_pos = 0;
	logic       ring_wrap = 1'b0;
	logic       log_live = 1'b0;
	int         snap_at = 0;
	logic       snap_wrap = 1'b0;
	logic       snap_ok = 1'b0;

	ctl_pkg::out_item_t expected_reads [$];
	int         failures = 0;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	int         gen_fill = 0;
	int         gen_snap = 0;
	dir_row_t   directed_rows [22];

	circular_trace_log_with_snapshot_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic trace_log_predict(input ctl_pkg::in_item_t it, output logic emits,
			output ctl_pkg::out_item_t res);
		int pos;
		int total;
		int start;
		int len;
		int room;
		int idx;
		emits = 1'b0;
		res = '0;
		case (it.cmd)
			ctl_pkg::CMD_APPEND: begin
				mirror_store[int'(log_bank) * int'(ctl_pkg::RING_BYTES) + wr_pos] =
					it.data_byte;
				pos = wr_pos + 1;
				if (pos >= int'(ctl_pkg::RING_BYTES)) begin
					pos = 0;
					ring_wrap = 1'b1;
				end
				wr_pos = pos;
			end
			ctl_pkg::CMD_RESTART: begin
				if (log_live) begin
					snap_at = wr_pos;
					snap_wrap = ring_wrap;
					snap_ok = 1'b1;
					log_bank = log_bank ^ 1'b1;
				end
				log_live = 1'b1;
				wr_pos = 0;
				ring_wrap = 1'b0;
				mirror_store[int'(log_bank) * int'(ctl_pkg::RING_BYTES)] = 8'h00;
			end
			ctl_pkg::CMD_READ: begin
				emits = 1'b1;
				len = 0;
				room = int'(it.read_room);
				idx = int'(it.read_index);
				if (snap_ok && room != 0) begin
					if (snap_wrap) begin
						total = int'(ctl_pkg::RING_BYTES);
						start = snap_at;
					end else begin
						total = snap_at;
						start = 0;
					end
					len = (room - 1 < total) ? room - 1 : total;
					if (idx < len) begin
						res.in_range = 1'b1;
						res.out_byte = mirror_store[
							int'(log_bank ^ 1'b1) * int'(ctl_pkg::RING_BYTES)
							+ (start + idx) % int'(ctl_pkg::RING_BYTES)];
					end
				end
				res.readable_length = len[ctl_pkg::LEN_W-1:0];
				res.snapshot_present = snap_ok;
			end
			default: begin
			end
		endcase
	endtask

	task automatic report(input string what, input ctl_pkg::out_item_t want,
			input ctl_pkg::out_item_t got);
		failures++;
		if (failures <= 10)
			$display("%0t %s: want byte %02h hit %0d len %0d present %0d,",
				$time, what, want.out_byte, want.in_range, want.readable_length,
				want.snapshot_present,
				" got byte %02h hit %0d len %0d present %0d",
				got.out_byte, got.in_range, got.readable_length,
				got.snapshot_present);
	endtask

	always @(posedge clk) begin : monitor
		ctl_pkg::out_item_t predicted;
		ctl_pkg::out_item_t want;
		logic      emits;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_reads.size() == 0) begin
					report("result with no read pending", '0, out_data);
				end else begin
					want = expected_reads.pop_front();
					if (want.out_byte !== out_data.out_byte
							|| want.in_range !== out_data.in_range
							|| want.readable_length !== out_data.readable_length
							|| want.snapshot_present !== out_data.snapshot_present)
						report("read result mismatch", want, out_data);
				end
			end
			if (in_valid && in_ready) begin
				trace_log_predict(in_data, emits, predicted);
				if (emits)
					expected_reads.push_back(row_fixed ? row_expect : predicted);
			end
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

	function automatic dir_row_t trace_row(logic [1:0] cmd, int data, int idx, int room,
			logic fixed, int b, int hit, int len, int pres);
		dir_row_t r;
		r.stim.cmd = cmd;
		r.stim.data_byte = 8'(data);
		r.stim.read_index = ctl_pkg::IDX_W'(idx);
		r.stim.read_room = ctl_pkg::ROOM_W'(room);
		r.fixed = fixed;
		r.want.out_byte = 8'(b);
		r.want.in_range = 1'(hit);
		r.want.readable_length = ctl_pkg::LEN_W'(len);
		r.want.snapshot_present = 1'(pres);
		return r;
	endfunction

	function automatic ctl_pkg::in_item_t random_item(logic [1:0] cmd);
		ctl_pkg::in_item_t it;
		it.cmd = cmd;
		it.data_byte = 8'($urandom_range(0, 255));
		it.read_index = ctl_pkg::IDX_W'($urandom_range(0, 8191));
		it.read_room = ctl_pkg::ROOM_W'($urandom_range(0, 16383));
		return it;
	endfunction

	// reads mostly aimed around the current snapshot length
	function automatic ctl_pkg::in_item_t aimed_read();
		ctl_pkg::in_item_t it;
		int r;
		it = random_item(ctl_pkg::CMD_READ);
		if (gen_snap > 0 && $urandom_range(0, 99) < 75)
			it.read_index = ctl_pkg::IDX_W'($urandom_range(0,
				(gen_snap > 8191) ? 8191 : gen_snap));
		r = $urandom_range(0, 99);
		if (r < 45)
			it.read_room = ctl_pkg::ROOM_W'(ctl_pkg::RING_BYTES + 1);
		else if (r < 70)
			it.read_room = ctl_pkg::ROOM_W'($urandom_range(0, gen_snap + 2));
		else if (r >= 95)
			it.read_room = '0;
		return it;
	endfunction

	function automatic ctl_pkg::in_item_t noise_item();
		return random_item(($urandom_range(0, 1) == 1) ? CMD_UNUSED
			: 2'($urandom_range(0, 3)));
	endfunction

	task automatic send(input ctl_pkg::in_item_t it, input logic fixed,
			input ctl_pkg::out_item_t want);
		in_valid <= 1'b1;
		in_data <= it;
		row_fixed <= fixed;
		row_expect <= want;
		if (it.cmd == ctl_pkg::CMD_APPEND && gen_fill < int'(ctl_pkg::RING_BYTES)) begin
			gen_fill++;
		end else if (it.cmd == ctl_pkg::CMD_RESTART) begin
			gen_snap = gen_fill;
			gen_fill = 0;
		end
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
	endtask

	// hold the sender off until every read result has been transferred
	task automatic drain();
		int n;
		in_valid <= 1'b0;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while (expected_reads.size() != 0 && n < 20000);
		while (expected_reads.size() != 0)
			report("read result never arrived", expected_reads.pop_front(), '0);
	endtask

	initial begin : stimulus
		int ph;
		int ep;
		int n;
		int m;
		int k;
		int r;
		logic wrap_ep;
		for (k = 0; k < ctl_pkg::STORE_DEPTH; k++)
			mirror_store[k] = 8'h00;
		directed_rows = '{
			trace_row(ctl_pkg::CMD_READ,      0,    0,  8193, 1'b1,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_RESTART,   0,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_READ,      0,    0,   100, 1'b1,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_APPEND,    0,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_APPEND,  255,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_APPEND,  165,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_RESTART,   0,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_READ,      0,    0,  8193, 1'b1,   0, 1, 3, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    1,  8193, 1'b1, 255, 1, 3, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    2, 16383, 1'b1, 165, 1, 3, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    3,  8193, 1'b1,   0, 0, 3, 1),
			trace_row(ctl_pkg::CMD_READ,      0, 8191,  8193, 1'b1,   0, 0, 3, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    0,     0, 1'b1,   0, 0, 0, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    0,     1, 1'b1,   0, 0, 0, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    0,     2, 1'b1,   0, 1, 1, 1),
			trace_row(CMD_UNUSED,           255, 8191, 16383, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_APPEND,   90,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_RESTART,   0,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_READ,      0,    0,  8193, 1'b1,  90, 1, 1, 1),
			trace_row(ctl_pkg::CMD_READ,      0,    1,  8193, 1'b1,   0, 0, 1, 1),
			trace_row(ctl_pkg::CMD_RESTART,   0,    0,     0, 1'b0,   0, 0, 0, 0),
			trace_row(ctl_pkg::CMD_READ,      0,    0,  8193, 1'b1,   0, 0, 0, 1)
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);

		for (ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 59;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 59;
				end
				default: begin
					src_idle_pct = 19;
					sink_stall_pct = 19;
				end
			endcase
			for (ep = 0; ep < 7; ep++) begin
				// one ring filled exactly to the end, one run past it
				wrap_ep = (ph == 0 && ep == 2) || (ph == 3 && ep == 4);
				if (wrap_ep) begin
					send(random_item(ctl_pkg::CMD_RESTART), 1'b0, '0);
					n = int'(ctl_pkg::RING_BYTES) + ((ph == 0) ? 0 : $urandom_range(1, 400));
				end else begin
					n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 30)
						: $urandom_range(31, 200);
				end
				for (k = 0; k < n; k++) begin
					r = $urandom_range(0, 99);
					if (wrap_ep || r < 88)
						send(random_item(ctl_pkg::CMD_APPEND), 1'b0, '0);
					else if (r < 96)
						send(aimed_read(), 1'b0, '0);
					else
						send(noise_item(), 1'b0, '0);
				end
				send(random_item(ctl_pkg::CMD_RESTART), 1'b0, '0);
				m = wrap_ep ? 64 : $urandom_range(4, 16);
				for (k = 0; k < m; k++) begin
					r = $urandom_range(0, 99);
					if (r < 80)
						send(aimed_read(), 1'b0, '0);
					else if (r < 93)
						send(random_item(ctl_pkg::CMD_APPEND), 1'b0, '0);
					else
						send(noise_item(), 1'b0, '0);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/ctl_pkg.sv
rtl/core/ctl_ram.sv
rtl/core/ctl_front.sv
rtl/core/ctl_queue.sv
rtl/core/ctl_back.sv
rtl/core/circular_trace_log_with_snapshot_top.sv
dv/tb_circular_trace_log_with_snapshot_top.sv
